/* rtl/ptc_pkg.sv */
`timescale 1ns / 1ps
// Package for the PID turn controller: register indexes, item codes, reset values
// and the structs that pass between the controller stages. No dependencies.
package ptc_pkg;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TARGET         = 3'd0,
      REG_WAIT_MS        = 3'd1,
      REG_OUTPUT_LIMIT   = 3'd2,
      REG_KP_GAIN        = 3'd3,
      REG_KI_GAIN        = 3'd4,
      REG_KD_GAIN        = 3'd5,
      REG_INTEGRAL_LIMIT = 3'd6,
      REG_INTEGRAL_ZONE  = 3'd7
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_SAMPLE = 1'b0,
      OP_START  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      RES_POWER = 2'd0,
      RES_CLEAR = 2'd1,
      RES_DONE  = 2'd2
   } res_kind_type;

   localparam logic [15:0] MIN_WAIT_MS    = 16'd250;
   localparam int          SETTLE_ERROR   = 30;

   localparam logic [15:0] RST_WAIT_MS        = 16'd250;
   localparam logic [6:0]  RST_OUTPUT_LIMIT   = 7'd127;
   localparam logic [15:0] RST_KP_GAIN        = 16'd51;
   localparam logic [15:0] RST_KI_GAIN        = 16'd13;
   localparam logic [15:0] RST_KD_GAIN        = 16'd128;
   localparam logic [14:0] RST_INTEGRAL_LIMIT = 15'd1000;
   localparam logic [14:0] RST_INTEGRAL_ZONE  = 15'd30;

   typedef struct packed {
      logic [15:0] wait_ms;
      logic [6:0]  output_limit;
      logic [15:0] kp_gain;
      logic [15:0] ki_gain;
      logic [15:0] kd_gain;
      logic [14:0] integral_limit;
      logic [14:0] integral_zone;
   } cfg_type;

   typedef struct packed {
      res_kind_type kind;
      logic         err_neg;
      logic         integ_neg;
      logic         diff_neg;
   } mid_ctl_type;

endpackage

/* rtl/ptc_req_if.sv */
`timescale 1ns / 1ps
// Input channel of the PID turn controller: one start command or heading sample per item.
// Depends on nothing.
interface ptc_req_if #(
   parameter int DataWidth = 16
);
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic signed [DataWidth-1:0] measured;
   logic [7:0]                  elapsed_ms;

   modport source (output valid, opcode, measured, elapsed_ms, input ready);
   modport sink (input valid, opcode, measured, elapsed_ms, output ready);
endinterface

/* rtl/ptc_rsp_if.sv */
`timescale 1ns / 1ps
// Result channel of the PID turn controller: drive powers and the done flag per item.
// Depends on nothing.
interface ptc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] left_power;
   logic signed [7:0] right_power;
   logic              done_res;

   modport source (output valid, left_power, right_power, done_res, input ready);
   modport sink (input valid, left_power, right_power, done_res, output ready);
endinterface

/* rtl/ptc_csr_if.sv */
`timescale 1ns / 1ps
// Configuration write channel of the PID turn controller.
// Depends on ptc_pkg for the index width.
interface ptc_csr_if #(
   parameter int DataWidth = 16
);
   logic                            valid;
   logic                            ready;
   logic [ptc_pkg::CSR_INDEX_W-1:0] wr_index;
   logic [DataWidth-1:0]            wr_data;

   modport source (output valid, wr_index, wr_data, input ready);
   modport sink (input valid, wr_index, wr_data, output ready);
endinterface

/* rtl/ptc_csr_regs.sv */
`timescale 1ns / 1ps
// Configuration registers of the PID turn controller, written through the csr channel.
// Depends on ptc_pkg and ptc_csr_if.
module ptc_csr_regs #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   ptc_csr_if.sink                      csr_chan,
   output ptc_pkg::cfg_type             cfg,
   output logic signed [DATA_WIDTH-1:0] target
);
   import ptc_pkg::*;

   cfg_type                      cfg_ff;
   logic signed [DATA_WIDTH-1:0] target_ff;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;
   assign target         = target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff             <= '0;
         cfg_ff.wait_ms        <= RST_WAIT_MS;
         cfg_ff.output_limit   <= RST_OUTPUT_LIMIT;
         cfg_ff.kp_gain        <= RST_KP_GAIN;
         cfg_ff.ki_gain        <= RST_KI_GAIN;
         cfg_ff.kd_gain        <= RST_KD_GAIN;
         cfg_ff.integral_limit <= RST_INTEGRAL_LIMIT;
         cfg_ff.integral_zone  <= RST_INTEGRAL_ZONE;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.wr_index))
            REG_TARGET:         target_ff             <= csr_chan.wr_data[DATA_WIDTH-1:0];
            REG_WAIT_MS:        cfg_ff.wait_ms        <= csr_chan.wr_data[15:0];
            REG_OUTPUT_LIMIT:   cfg_ff.output_limit   <= csr_chan.wr_data[6:0];
            REG_KP_GAIN:        cfg_ff.kp_gain        <= csr_chan.wr_data[15:0];
            REG_KI_GAIN:        cfg_ff.ki_gain        <= csr_chan.wr_data[15:0];
            REG_KD_GAIN:        cfg_ff.kd_gain        <= csr_chan.wr_data[15:0];
            REG_INTEGRAL_LIMIT: cfg_ff.integral_limit <= csr_chan.wr_data[14:0];
            REG_INTEGRAL_ZONE:  cfg_ff.integral_zone  <= csr_chan.wr_data[14:0];
            default: begin
            end
         endcase
      end
   end

endmodule

/* rtl/ptc_state_stage.sv */
`timescale 1ns / 1ps
// First stage of the PID turn controller: error, integral, derivative difference and
// settle timer, with the loop state. Depends on ptc_pkg.
module ptc_state_stage #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         mid_en,
   input  logic                         opcode,
   input  logic signed [DATA_WIDTH-1:0] measured,
   input  logic [7:0]                   elapsed_ms,
   input  ptc_pkg::cfg_type             cfg,
   input  logic signed [DATA_WIDTH-1:0] target,
   output logic                         mid_valid,
   output ptc_pkg::mid_ctl_type         mid_ctl,
   output logic [DATA_WIDTH:0]          err_mag,
   output logic [14:0]                  integ_mag,
   output logic [DATA_WIDTH+1:0]        diff_mag
);
   import ptc_pkg::*;

   localparam int EW  = DATA_WIDTH + 1;
   localparam int DFW = DATA_WIDTH + 2;
   localparam int MW  = (EW > 15) ? EW : 15;
   localparam int SW  = ((EW > 16) ? EW : 16) + 1;
   localparam logic signed [EW-1:0] SettleErr = EW'(SETTLE_ERROR);

   logic signed [15:0]   integ_ff;
   logic signed [EW-1:0] prev_ff;
   logic [15:0]          timer_ff;
   logic                 settled_ff;
   logic                 finished_ff;
   logic                 mid_valid_ff;
   mid_ctl_type          mid_ctl_ff;
   logic [EW-1:0]        err_mag_ff;
   logic [14:0]          integ_mag_ff;
   logic [DFW-1:0]       diff_mag_ff;

   logic signed [EW-1:0]  err;
   logic [EW-1:0]         err_abs;
   logic                  err_zero;
   logic                  in_zone;
   logic signed [SW-1:0]  integ_sum;
   logic signed [SW-1:0]  integ_lim;
   logic signed [SW-1:0]  integ_pre;
   logic signed [SW-1:0]  integ_clamp;
   logic signed [15:0]    integ_in;
   logic [14:0]           integ_abs;
   logic signed [DFW-1:0] diff;
   logic [DFW-1:0]        diff_abs;
   logic [16:0]           timer_sum;
   logic [15:0]           timer_in;
   logic                  settled_in;
   logic [15:0]           wait_eff;
   logic                  done_now;
   logic                  is_start;
   res_kind_type          kind_in;

   assign is_start = (opcode_type'(opcode) == OP_START);
   assign err      = EW'(target) - EW'(measured);
   assign err_zero = (err == '0);
   assign err_abs  = err[EW-1] ? EW'(-err) : EW'(err);
   assign in_zone  = (MW'(err_abs) < MW'(cfg.integral_zone));

   assign integ_sum = SW'(integ_ff) + SW'(err);
   assign integ_lim = SW'({1'b0, cfg.integral_limit});

   always_comb begin
      integ_pre = (in_zone && !err_zero) ? integ_sum : '0;
      if (integ_pre > integ_lim) begin
         integ_clamp = integ_lim;
      end else if (integ_pre < -integ_lim) begin
         integ_clamp = -integ_lim;
      end else begin
         integ_clamp = integ_pre;
      end
   end

   assign integ_in  = integ_clamp[15:0];
   assign integ_abs = integ_in[15] ? 15'(-integ_in) : integ_in[14:0];

   assign diff = DFW'(err) - DFW'(prev_ff);

   always_comb begin
      if (err_zero) begin
         diff_abs = '0;
      end else if (diff[DFW-1]) begin
         diff_abs = DFW'(-diff);
      end else begin
         diff_abs = DFW'(diff);
      end
   end

   assign timer_sum  = {1'b0, timer_ff} + 17'(elapsed_ms);
   assign settled_in = settled_ff || (err < SettleErr);

   always_comb begin
      if (!settled_in) begin
         timer_in = '0;
      end else if (timer_sum[16]) begin
         timer_in = 16'hFFFF;
      end else begin
         timer_in = timer_sum[15:0];
      end
   end

   assign wait_eff = (cfg.wait_ms < MIN_WAIT_MS) ? MIN_WAIT_MS : cfg.wait_ms;
   assign done_now = (timer_in >= wait_eff);

   always_comb begin
      if (is_start) begin
         kind_in = RES_CLEAR;
      end else if (finished_ff || done_now) begin
         kind_in = RES_DONE;
      end else begin
         kind_in = RES_POWER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff     <= '0;
         prev_ff      <= '0;
         timer_ff     <= '0;
         settled_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
      end else begin
         if (mid_en) begin
            mid_valid_ff <= accept;
         end
         if (accept) begin
            if (is_start) begin
               integ_ff    <= '0;
               prev_ff     <= '0;
               timer_ff    <= '0;
               settled_ff  <= 1'b0;
               finished_ff <= 1'b0;
            end else if (!finished_ff) begin
               integ_ff    <= integ_in;
               prev_ff     <= err;
               timer_ff    <= timer_in;
               settled_ff  <= settled_in;
               finished_ff <= done_now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_ctl_ff.kind      <= kind_in;
         mid_ctl_ff.err_neg   <= err[EW-1];
         mid_ctl_ff.integ_neg <= integ_in[15];
         mid_ctl_ff.diff_neg  <= diff[DFW-1];
         err_mag_ff           <= err_abs;
         integ_mag_ff         <= integ_abs;
         diff_mag_ff          <= diff_abs;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid_ctl   = mid_ctl_ff;
   assign err_mag   = err_mag_ff;
   assign integ_mag = integ_mag_ff;
   assign diff_mag  = diff_mag_ff;

endmodule

/* rtl/ptc_power_stage.sv */
`timescale 1ns / 1ps
// Second stage of the PID turn controller: the three gain products, their sum,
// saturation to the output limit and the result register. Depends on ptc_pkg.
module ptc_power_stage #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  out_en,
   input  logic                  mid_valid,
   input  ptc_pkg::mid_ctl_type  mid_ctl,
   input  logic [DATA_WIDTH:0]   err_mag,
   input  logic [14:0]           integ_mag,
   input  logic [DATA_WIDTH+1:0] diff_mag,
   input  ptc_pkg::cfg_type      cfg,
   output logic                  rsp_valid,
   output logic signed [7:0]     left_power,
   output logic signed [7:0]     right_power,
   output logic                  done_res
);
   import ptc_pkg::*;

   localparam int EW  = DATA_WIDTH + 1;
   localparam int DFW = DATA_WIDTH + 2;
   localparam int PW  = DATA_WIDTH + 13;

   logic              rsp_valid_ff;
   logic signed [7:0] left_ff;
   logic signed [7:0] right_ff;
   logic              done_ff;

   logic [EW+15:0]        p_prod;
   logic [30:0]           i_prod;
   logic [DFW+15:0]       d_prod;
   logic signed [PW-1:0]  p_term;
   logic signed [PW-1:0]  i_term;
   logic signed [PW-1:0]  d_term;
   logic signed [PW-1:0]  power;
   logic signed [PW-1:0]  out_lim;
   logic signed [PW-1:0]  power_sat;
   logic signed [7:0]     left_in;
   logic signed [7:0]     right_in;
   logic                  done_in;

   assign p_prod = cfg.kp_gain * err_mag;
   assign i_prod = cfg.ki_gain * integ_mag;
   assign d_prod = cfg.kd_gain * diff_mag;

   assign p_term = mid_ctl.err_neg   ? -PW'(p_prod[EW+15:8])  : PW'(p_prod[EW+15:8]);
   assign i_term = mid_ctl.integ_neg ? -PW'(i_prod[30:8])     : PW'(i_prod[30:8]);
   assign d_term = mid_ctl.diff_neg  ? -PW'(d_prod[DFW+15:8]) : PW'(d_prod[DFW+15:8]);

   assign power   = p_term + i_term + d_term;
   assign out_lim = PW'(cfg.output_limit);

   always_comb begin
      if (power > out_lim) begin
         power_sat = out_lim;
      end else if (power < -out_lim) begin
         power_sat = -out_lim;
      end else begin
         power_sat = power;
      end
   end

   always_comb begin
      unique case (mid_ctl.kind)
         RES_POWER: begin
            left_in  = power_sat[7:0];
            right_in = -power_sat[7:0];
            done_in  = 1'b0;
         end
         RES_DONE: begin
            left_in  = '0;
            right_in = '0;
            done_in  = 1'b1;
         end
         default: begin
            left_in  = '0;
            right_in = '0;
            done_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= mid_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && mid_valid) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign left_power  = left_ff;
   assign right_power = right_ff;
   assign done_res    = done_ff;

endmodule

/* rtl/pid_turn_controller.sv */
`timescale 1ns / 1ps
// Top level of the PID turn controller: csr registers, state stage and power stage.
// Depends on ptc_pkg, the three channel interfaces and the ptc_* stage modules.
//
// Each req item is either a start command, which clears the loop state, or one
// heading sample with the milliseconds since the previous one. Every item yields
// exactly one rsp item: left and right drive power and the done flag.
// The csr channel writes one register per item and is always ready; the user
// must write it only while no item is in flight: the block does not enforce it.
// A req item is registered in the state stage when accepted, then in the power
// stage result register before it shows on rsp. One item is accepted per cycle
// while req ready is high: the loop state (integral, last error, settle timer,
// flags) is updated in the cycle the item is taken, and the gain products run in
// the following stage. When rsp is stalled, the result register holds and the
// pipeline fills; req ready drops only once both stages hold an item.
// Synchronous reset restores the register reset values, clears the loop state and
// empties the pipeline.
module pid_turn_controller #(
   parameter int DATA_WIDTH = 16
) (
   input logic        clock,
   input logic        reset,
   ptc_req_if.sink    req_chan,
   ptc_rsp_if.source  rsp_chan,
   ptc_csr_if.sink    csr_chan
);
   import ptc_pkg::*;

   cfg_type                      cfg;
   logic signed [DATA_WIDTH-1:0] target;
   logic                         mid_valid;
   mid_ctl_type                  mid_ctl;
   logic [DATA_WIDTH:0]          err_mag;
   logic [14:0]                  integ_mag;
   logic [DATA_WIDTH+1:0]        diff_mag;
   logic                         out_en;
   logic                         mid_en;
   logic                         accept;

   assign out_en         = !rsp_chan.valid || rsp_chan.ready;
   assign mid_en         = !mid_valid || out_en;
   assign req_chan.ready = mid_en;
   assign accept         = req_chan.valid && mid_en;

   ptc_csr_regs #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg),
      .target   (target)
   );

   ptc_state_stage #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_state_stage (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mid_en     (mid_en),
      .opcode     (req_chan.opcode),
      .measured   (req_chan.measured),
      .elapsed_ms (req_chan.elapsed_ms),
      .cfg        (cfg),
      .target     (target),
      .mid_valid  (mid_valid),
      .mid_ctl    (mid_ctl),
      .err_mag    (err_mag),
      .integ_mag  (integ_mag),
      .diff_mag   (diff_mag)
   );

   ptc_power_stage #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_power_stage (
      .clock       (clock),
      .reset       (reset),
      .out_en      (out_en),
      .mid_valid   (mid_valid),
      .mid_ctl     (mid_ctl),
      .err_mag     (err_mag),
      .integ_mag   (integ_mag),
      .diff_mag    (diff_mag),
      .cfg         (cfg),
      .rsp_valid   (rsp_chan.valid),
      .left_power  (rsp_chan.left_power),
      .right_power (rsp_chan.right_power),
      .done_res    (rsp_chan.done_res)
   );

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("Result valid right after reset.");

   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.done_res |->
         rsp_chan.left_power == 8'sd0 && rsp_chan.right_power == 8'sd0)
      else $error("Done item carries nonzero power.");

   a_sides_opposed: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.right_power == 8'(-rsp_chan.left_power))
      else $error("Right power is not the negated left power.");

   a_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         rsp_chan.left_power <= $signed({1'b0, cfg.output_limit}) &&
         rsp_chan.left_power >= -$signed({1'b0, cfg.output_limit}))
      else $error("Left power exceeds the output limit.");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pid_turn_controller: random start commands and heading samples
// under several register settings, each result checked against an in-bench PID turn predictor.
// Depends on ptc_pkg, the ptc_req_if, ptc_rsp_if and ptc_csr_if interfaces and the controller.
module testbench;
   import ptc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int ITEM_TARGET  = 1550;
   localparam int PHASE_ITEMS  = 190;

   typedef struct {
      opcode_type         op;
      logic signed [15:0] measured;
      logic [7:0]         elapsed;
      bit                 hold_until_drained;
   } heading_item_type;

   typedef struct {
      logic signed [7:0] left;
      logic signed [7:0] right;
      logic              done;
   } drive_result_type;

   logic clock;
   logic reset;

   ptc_req_if #(.DataWidth(16)) req_chan ();
   ptc_rsp_if                   rsp_chan ();
   ptc_csr_if #(.DataWidth(16)) csr_chan ();

   pid_turn_controller #(.DATA_WIDTH(16)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   heading_item_type heading_q[$];
   drive_result_type drive_expect_q[$];
   heading_item_type on_wire;

   logic signed [15:0] cfg_target;
   cfg_type            cfg;
   longint             loop_integral;
   longint             loop_last_error;
   longint             loop_timer;
   bit                 loop_settled;
   bit                 loop_finished;

   int items_queued;
   int items_driven;
   int starts_queued;
   int results_checked;
   int done_results;
   int settings_run;
   int mismatch_count;
   int cycle_count;
   int sender_gap;
   int sender_quiet;
   int receiver_stall;
   int receiver_quiet;

   function automatic void clear_turn_state();
      loop_integral   = 0;
      loop_last_error = 0;
      loop_timer      = 0;
      loop_settled    = 1'b0;
      loop_finished   = 1'b0;
   endfunction

   function automatic longint scale_q88(logic [15:0] gain, longint value);
      longint g;
      longint mag_v;
      longint q;
      g = longint'(gain);
      mag_v = (value < 0) ? -value : value;
      q = (g * mag_v) >>> 8;
      return (value < 0) ? -q : q;
   endfunction

   function automatic drive_result_type turn_step(heading_item_type it);
      longint err, mag, integ, slope, power, neg;
      longint zone, ilim, olim, wait_lim, timer;
      drive_result_type res;
      res.left  = '0;
      res.right = '0;
      res.done  = 1'b0;
      if (it.op == OP_START) begin
         clear_turn_state();
         return res;
      end
      if (loop_finished) begin
         res.done = 1'b1;
         return res;
      end
      zone = longint'(cfg.integral_zone);
      ilim = longint'(cfg.integral_limit);
      olim = longint'(cfg.output_limit);
      err  = longint'(cfg_target) - longint'(it.measured);
      mag  = (err < 0) ? -err : err;

      integ = (mag < zone && err != 0) ? loop_integral + err : 0;
      if (integ > ilim) integ = ilim;
      if (integ < -ilim) integ = -ilim;
      loop_integral = integ;

      slope = (err == 0) ? 0 : scale_q88(cfg.kd_gain, err - loop_last_error);
      loop_last_error = err;

      power = scale_q88(cfg.kp_gain, err) + scale_q88(cfg.ki_gain, integ) + slope;
      if (power > olim) power = olim;
      else if (power < -olim) power = -olim;

      timer = loop_timer + longint'(it.elapsed);
      if (timer > 65535) timer = 65535;
      if (err < SETTLE_ERROR) loop_settled = 1'b1;
      if (!loop_settled) timer = 0;
      loop_timer = timer;

      wait_lim = (cfg.wait_ms < MIN_WAIT_MS) ? longint'(MIN_WAIT_MS) : longint'(cfg.wait_ms);
      if (loop_timer >= wait_lim) begin
         loop_finished = 1'b1;
         res.done = 1'b1;
         return res;
      end
      neg = -power;
      res.left  = power[7:0];
      res.right = neg[7:0];
      return res;
   endfunction

   function automatic int pick_gap(inout int quiet);
      int roll;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         quiet = $urandom_range(40, 200);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void queue_item(opcode_type op, int heading, int elapsed, bit hold);
      heading_item_type it;
      it.op                 = op;
      it.measured           = heading[15:0];
      it.elapsed            = elapsed[7:0];
      it.hold_until_drained = hold;
      heading_q.push_back(it);
      items_queued++;
      if (op == OP_START) starts_queued++;
   endfunction

   // A turn starts with a start command and then converges on the target,
   // with occasional overshoot and a little sensor noise.
   function automatic void queue_turn(int samples, int start_err, int el_lo, int el_hi);
      int cur;
      int heading;
      int tgt;
      tgt = int'(cfg_target);
      cur = start_err;
      queue_item(OP_START, $urandom_range(0, 65535), $urandom_range(0, 255),
                 $urandom_range(0, 199) == 0);
      repeat (samples) begin
         heading = tgt - cur;
         if (heading > 32767) heading = 32767;
         if (heading < -32768) heading = -32768;
         queue_item(OP_SAMPLE, heading, $urandom_range(el_lo, el_hi),
                    $urandom_range(0, 199) == 0);
         cur = (cur * int'($urandom_range(40, 95))) / 100 + int'($urandom_range(0, 12)) - 6;
         if ($urandom_range(0, 7) == 0) cur = -cur;
      end
   endfunction

   task automatic write_csr(csr_index_type idx, logic [15:0] data);
      @(posedge clock);
      csr_chan.valid    <= 1'b1;
      csr_chan.wr_index <= idx;
      csr_chan.wr_data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         REG_TARGET:         cfg_target = data;
         REG_WAIT_MS:        cfg.wait_ms = data;
         REG_OUTPUT_LIMIT:   cfg.output_limit = data[6:0];
         REG_KP_GAIN:        cfg.kp_gain = data;
         REG_KI_GAIN:        cfg.ki_gain = data;
         REG_KD_GAIN:        cfg.kd_gain = data;
         REG_INTEGRAL_LIMIT: cfg.integral_limit = data[14:0];
         REG_INTEGRAL_ZONE:  cfg.integral_zone = data[14:0];
         default: ;
      endcase
      csr_chan.valid <= 1'b0;
   endtask

   task automatic program_controller(logic [15:0] tgt, logic [15:0] wait_ms,
                                     logic [15:0] out_lim, logic [15:0] kp,
                                     logic [15:0] ki, logic [15:0] kd,
                                     logic [15:0] int_lim, logic [15:0] int_zone);
      write_csr(REG_TARGET, tgt);
      write_csr(REG_WAIT_MS, wait_ms);
      write_csr(REG_OUTPUT_LIMIT, out_lim);
      write_csr(REG_KP_GAIN, kp);
      write_csr(REG_KI_GAIN, ki);
      write_csr(REG_KD_GAIN, kd);
      write_csr(REG_INTEGRAL_LIMIT, int_lim);
      write_csr(REG_INTEGRAL_ZONE, int_zone);
      settings_run++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (heading_q.size() != 0 || req_chan.valid || drive_expect_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random_phase();
      int first;
      int len;
      int start_err;
      int lo;
      int hi;
      program_controller(16'($urandom_range(0, 65535)),
                         16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(250, 2500)),
                         16'($urandom_range(0, 127)),
                         16'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 2048)),
                         16'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 1024)),
                         16'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 2048)),
                         16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                         : $urandom_range(0, 4000)),
                         16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                         : $urandom_range(0, 300)));
      first = items_queued;
      while (items_queued - first < PHASE_ITEMS && items_queued < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 88) begin
            len = $urandom_range(4, 50);
            start_err = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 3000);
            if ($urandom_range(0, 1)) start_err = -start_err;
            if ($urandom_range(0, 4) == 0) begin
               lo = 0;
               hi = 255;
            end else begin
               lo = 20;
               hi = 60;
            end
            queue_turn(len, start_err, lo, hi);
         end else begin
            repeat ($urandom_range(1, 5))
               queue_item(opcode_type'($urandom_range(0, 1)), $urandom_range(0, 65535),
                          $urandom_range(0, 255), 1'b0);
         end
      end
      wait_drained();
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         sender_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            drive_expect_q.push_back(turn_step(on_wire));
            items_driven++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (sender_gap > 0) begin
               sender_gap--;
               req_chan.valid <= 1'b0;
            end else if (heading_q.size() == 0 ||
                         (heading_q[0].hold_until_drained && drive_expect_q.size() != 0)) begin
               req_chan.valid <= 1'b0;
            end else begin
               on_wire = heading_q.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.opcode     <= on_wire.op;
               req_chan.measured   <= on_wire.measured;
               req_chan.elapsed_ms <= on_wire.elapsed;
               sender_gap = pick_gap(sender_quiet);
            end
         end
      end
   end

   always @(posedge clock) begin
      drive_result_type exp_res;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         receiver_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_checked++;
            if (rsp_chan.done_res === 1'b1) done_results++;
            if (drive_expect_q.size() == 0) begin
               $display("%0t: result with nothing expected, got left %0d right %0d done %0d",
                        $time, rsp_chan.left_power, rsp_chan.right_power, rsp_chan.done_res);
               mismatch_count++;
            end else begin
               exp_res = drive_expect_q.pop_front();
               if (rsp_chan.left_power !== exp_res.left ||
                   rsp_chan.right_power !== exp_res.right ||
                   rsp_chan.done_res !== exp_res.done) begin
                  $display({"%0t: mismatch, expected left %0d right %0d done %0d,",
                            " got left %0d right %0d done %0d"},
                           $time, exp_res.left, exp_res.right, exp_res.done,
                           rsp_chan.left_power, rsp_chan.right_power, rsp_chan.done_res);
                  mismatch_count++;
               end
            end
         end
         if (receiver_stall > 0) begin
            receiver_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            receiver_stall = pick_gap(receiver_quiet);
         end
      end
   end

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.opcode     = OP_SAMPLE;
      req_chan.measured   = '0;
      req_chan.elapsed_ms = '0;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.wr_index   = REG_TARGET;
      csr_chan.wr_data    = '0;
      reset               = 1'b1;

      cfg_target         = '0;
      cfg.wait_ms        = RST_WAIT_MS;
      cfg.output_limit   = RST_OUTPUT_LIMIT;
      cfg.kp_gain        = RST_KP_GAIN;
      cfg.ki_gain        = RST_KI_GAIN;
      cfg.kd_gain        = RST_KD_GAIN;
      cfg.integral_limit = RST_INTEGRAL_LIMIT;
      cfg.integral_zone  = RST_INTEGRAL_ZONE;
      clear_turn_state();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      settings_run = 1;

      // Reset settings: zone edges, zero error, the signed settle compare,
      // reaching the wait, samples after finish and restarts mid-turn.
      queue_item(OP_START, -1, 255, 1'b0);
      queue_item(OP_SAMPLE, -32768, 255, 1'b0);
      queue_item(OP_SAMPLE, -100, 0, 1'b0);
      queue_item(OP_SAMPLE, -20, 40, 1'b0);
      queue_item(OP_SAMPLE, -20, 40, 1'b0);
      queue_item(OP_SAMPLE, 0, 40, 1'b0);
      queue_item(OP_SAMPLE, 29, 40, 1'b0);
      queue_item(OP_SAMPLE, 32767, 40, 1'b0);
      queue_item(OP_SAMPLE, -30, 49, 1'b0);
      queue_item(OP_SAMPLE, -31, 1, 1'b0);
      queue_item(OP_SAMPLE, 5, 255, 1'b0);
      queue_item(OP_START, 0, 0, 1'b0);
      queue_item(OP_SAMPLE, -29, 255, 1'b0);
      queue_item(OP_START, 32767, 0, 1'b0);
      queue_item(OP_SAMPLE, -30, 255, 1'b0);
      queue_item(OP_SAMPLE, -1, 200, 1'b0);
      queue_item(OP_START, 0, 128, 1'b0);
      queue_item(OP_SAMPLE, 1, 128, 1'b1);
      queue_item(OP_SAMPLE, -32768, 0, 1'b0);
      wait_drained();

      // Largest settings: full-scale error, heavy gains, timer saturation.
      program_controller(16'h7FFF, 16'hFFFF, 16'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'h7FFF, 16'h7FFF);
      queue_item(OP_START, 0, 0, 1'b0);
      queue_item(OP_SAMPLE, -32768, 255, 1'b0);
      queue_item(OP_SAMPLE, 32767, 255, 1'b0);
      queue_turn(300, 10, 200, 255);
      wait_drained();

      // Smallest settings: zero gains and limits, wait below the minimum.
      program_controller(16'h8000, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      queue_item(OP_START, 0, 0, 1'b0);
      queue_item(OP_SAMPLE, 32767, 255, 1'b0);
      queue_item(OP_SAMPLE, -32768, 255, 1'b0);
      queue_turn(40, 2000, 0, 255);
      wait_drained();

      while (items_queued < ITEM_TARGET)
         run_random_phase();

      wait_drained();
      repeat (8) @(posedge clock);
      $display("summary: %0d items driven (%0d start commands) under %0d register settings",
               items_driven, starts_queued, settings_run);
      $display("summary: %0d results checked, %0d with done set, %0d mismatches",
               results_checked, done_results, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
